// ===== rtl/ibs_pkg.sv =====
// ibs_pkg: shared constants for the interior box shrink block
// configuration register indexes, field widths and image count
// no dependencies
`timescale 1ns / 1ps

package ibs_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 23;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIODIC_ON = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_SIZE    = 1'd1;

  // periodic box edge
  localparam int BOX_SIZE_BITS = 23;
  localparam logic [BOX_SIZE_BITS-1:0] BOX_SIZE_RESET = 23'd1;

  // item command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CUT  = 1'b1;

  // overlap counter
  localparam int COUNT_BITS  = 5;
  localparam int IMAGE_COUNT = 27;

endpackage

// ===== rtl/ibs_item_if.sv =====
// ibs_item_if: valid/ready channel carrying one box item (command and corners)
// no package dependencies
`timescale 1ns / 1ps

interface ibs_item_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] lo_x;
  logic signed [COORD_BITS-1:0] lo_y;
  logic signed [COORD_BITS-1:0] lo_z;
  logic signed [COORD_BITS-1:0] hi_x;
  logic signed [COORD_BITS-1:0] hi_y;
  logic signed [COORD_BITS-1:0] hi_z;

  modport source (
    output valid, cmd, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
    input  ready
  );

  modport sink (
    input  valid, cmd, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
    output ready
  );
endinterface

// ===== rtl/ibs_result_if.sv =====
// ibs_result_if: valid/ready channel carrying the interior box and overlap count
// depends on ibs_pkg for the counter width
`timescale 1ns / 1ps

interface ibs_result_if
  import ibs_pkg::*;
#(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_lo_x;
  logic signed [COORD_BITS-1:0] out_lo_y;
  logic signed [COORD_BITS-1:0] out_lo_z;
  logic signed [COORD_BITS-1:0] out_hi_x;
  logic signed [COORD_BITS-1:0] out_hi_y;
  logic signed [COORD_BITS-1:0] out_hi_z;
  logic [COUNT_BITS-1:0]        overlap_count;

  modport source (
    output valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
    output overlap_count,
    input  ready
  );

  modport sink (
    input  valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
    input  overlap_count,
    output ready
  );
endinterface

// ===== rtl/ibs_mul.sv =====
// ibs_mul: unsigned multiplier with a registered product
// shared by every volume product of the block; no package dependencies
`timescale 1ns / 1ps

module ibs_mul #(
  parameter int WIDTH = 24
) (
  input  logic               clk,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [2*WIDTH-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
  end

endmodule

// ===== rtl/interior_box_shrink.sv =====
// interior_box_shrink keeps a local axis-aligned box and shrinks it against boxes
// of other domains. A load item (cmd 0) replaces the box and returns it with a
// count of zero. A cut item (cmd 1) is tested once unshifted, or, with
// periodic_on set, at 27 images shifted by -box_size, 0 or +box_size per axis
// (x outermost, z innermost), the box being updated after each image that
// overlaps it on all three axes. For such an image the six candidate volumes
// (trim below or above the overlap on each axis) are exact products of three
// extents, formed on one shared COORD_BITS x COORD_BITS multiplier as two
// partial products each, and compared in turn; the first largest wins. The
// input channel takes one item at a time; the result sits in an output
// register, so the next item may be accepted while the previous result still
// waits for its transfer. Configuration is to be written only while the block
// is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module interior_box_shrink
  import ibs_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  ibs_item_if.sink                  item,
  ibs_result_if.source              result
);

  localparam int CW = COORD_BITS;
  // shifted coordinates: coordinate plus or minus box size, without wrapping
  localparam int SW = ((CW > BOX_SIZE_BITS + 1) ? CW : BOX_SIZE_BITS + 1) + 1;
  localparam int PW = 2 * CW;   // product of two extents
  localparam int VW = 3 * CW;   // volume

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_PROD,
    ST_SPLIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACCUM,
    ST_CMP,
    ST_APPLY,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // image offset along one axis, in units of box size
  typedef enum logic [1:0] {
    OFF_NEG,
    OFF_ZERO,
    OFF_POS
  } offset_t;

  function automatic offset_t off_inc(offset_t o);
    offset_t r;
    unique case (o)
      OFF_NEG:  r = OFF_ZERO;
      OFF_ZERO: r = OFF_POS;
      default:  r = OFF_NEG;
    endcase
    return r;
  endfunction

  function automatic logic signed [SW-1:0] sx(logic signed [CW-1:0] c);
    return $signed({{(SW-CW){c[CW-1]}}, c});
  endfunction

  state_t state;

  // configuration
  logic                     periodic_on;
  logic [BOX_SIZE_BITS-1:0] box_size;

  // interior box
  logic signed [CW-1:0] low  [3];
  logic signed [CW-1:0] high [3];

  // cut box of the current item
  logic signed [CW-1:0] lo_q [3];
  logic signed [CW-1:0] hi_q [3];

  // image position and overlap of the current image
  offset_t              off      [3];
  offset_t              off_next [3];
  logic signed [SW-1:0] cmin_q   [3];
  logic signed [SW-1:0] cmax_q   [3];

  // candidate scan
  axis_t               axis;
  logic                side;       // 0 keeps below the overlap, 1 keeps above
  logic [CW-1:0]       p_lo;
  logic [CW-1:0]       p_hi;
  logic [VW-1:0]       acc;
  logic [VW-1:0]       best;
  axis_t               best_axis;
  logic                best_side;
  logic [COUNT_BITS-1:0] count;

  // shared multiplier
  logic [CW-1:0] mul_a;
  logic [CW-1:0] mul_b;
  logic [PW-1:0] prod;

  // combinational helpers
  logic signed [SW-1:0] bs_ext;
  logic signed [SW-1:0] shift   [3];
  logic signed [SW-1:0] a_sh    [3];
  logic signed [SW-1:0] b_sh    [3];
  logic signed [SW-1:0] cmin    [3];
  logic signed [SW-1:0] cmax    [3];
  logic [2:0]           axis_hit;
  logic                 overlap;
  logic                 last_image;
  logic [CW-1:0]        ext [3];
  logic [CW-1:0]        dlo [3];
  logic [CW-1:0]        dhi [3];
  logic [CW-1:0]        e1;
  logic [CW-1:0]        e2;
  logic [CW-1:0]        d_lo;
  logic [CW-1:0]        d_hi;
  logic [CW-1:0]        d;
  logic                 better;
  logic signed [CW-1:0] sel_low;
  logic signed [CW-1:0] sel_high;
  logic signed [CW-1:0] sel_cmin;
  logic signed [CW-1:0] sel_cmax;
  logic signed [CW-1:0] apply_val;

  ibs_mul #(
    .WIDTH(CW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign item.ready = (state == ST_IDLE);

  // overlap of the current image with the interior box, all three axes at once
  assign bs_ext = $signed({{(SW-BOX_SIZE_BITS){1'b0}}, box_size});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (off[k])
        OFF_NEG: shift[k] = -bs_ext;
        OFF_POS: shift[k] = bs_ext;
        default: shift[k] = '0;
      endcase
      a_sh[k]     = sx(lo_q[k]) + shift[k];
      b_sh[k]     = sx(hi_q[k]) + shift[k];
      cmin[k]     = (sx(low[k]) > a_sh[k]) ? sx(low[k]) : a_sh[k];
      cmax[k]     = (sx(high[k]) < b_sh[k]) ? sx(high[k]) : b_sh[k];
      axis_hit[k] = (cmax[k] > cmin[k]);
    end
  end

  assign overlap = &axis_hit;

  assign last_image = !periodic_on ||
                      ((off[0] == OFF_POS) && (off[1] == OFF_POS) && (off[2] == OFF_POS));

  // next image, z innermost
  always_comb begin
    off_next = off;
    if (off[2] != OFF_POS) begin
      off_next[2] = off_inc(off[2]);
    end else begin
      off_next[2] = OFF_NEG;
      if (off[1] != OFF_POS) begin
        off_next[1] = off_inc(off[1]);
      end else begin
        off_next[1] = OFF_NEG;
        off_next[0] = off_inc(off[0]);
      end
    end
  end

  // extents; valid as unsigned values once the image overlaps
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ext[k] = $unsigned(high[k]) - $unsigned(low[k]);
      dlo[k] = cmin_q[k][CW-1:0] - $unsigned(low[k]);
      dhi[k] = $unsigned(high[k]) - cmax_q[k][CW-1:0];
    end
  end

  // operands of the candidate on the current axis
  always_comb begin
    unique case (axis)
      AXIS_X: begin
        e1 = ext[1]; e2 = ext[2]; d_lo = dlo[0]; d_hi = dhi[0];
      end
      AXIS_Y: begin
        e1 = ext[2]; e2 = ext[0]; d_lo = dlo[1]; d_hi = dhi[1];
      end
      AXIS_Z: begin
        e1 = ext[0]; e2 = ext[1]; d_lo = dlo[2]; d_hi = dhi[2];
      end
      default: begin
        e1 = '0; e2 = '0; d_lo = '0; d_hi = '0;
      end
    endcase
  end

  assign d = side ? d_hi : d_lo;

  // multiplier schedule: extent product first, then two partial products
  assign mul_a = (state == ST_PROD) ? e1 : d;
  assign mul_b = (state == ST_PROD) ? e2 : ((state == ST_MUL_HI) ? p_hi : p_lo);

  // the first candidate is always taken, later ones only if strictly larger
  assign better = ((axis == AXIS_X) && !side) || (acc > best);

  // chosen trim
  always_comb begin
    unique case (best_axis)
      AXIS_X: begin
        sel_low = low[0]; sel_high = high[0];
        sel_cmin = cmin_q[0][CW-1:0]; sel_cmax = cmax_q[0][CW-1:0];
      end
      AXIS_Y: begin
        sel_low = low[1]; sel_high = high[1];
        sel_cmin = cmin_q[1][CW-1:0]; sel_cmax = cmax_q[1][CW-1:0];
      end
      AXIS_Z: begin
        sel_low = low[2]; sel_high = high[2];
        sel_cmin = cmin_q[2][CW-1:0]; sel_cmax = cmax_q[2][CW-1:0];
      end
      default: begin
        sel_low = '0; sel_high = '0; sel_cmin = '0; sel_cmax = '0;
      end
    endcase
  end

  assign apply_val = best_side ? sel_cmax : sel_cmin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
      periodic_on  <= 1'b0;
      box_size     <= BOX_SIZE_RESET;
      count        <= '0;
      axis         <= AXIS_X;
      side         <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        low[k]  <= '0;
        high[k] <= '0;
        off[k]  <= OFF_ZERO;
      end
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PERIODIC_ON: periodic_on <= cfg_data[0];
          CFG_BOX_SIZE:    box_size    <= cfg_data[BOX_SIZE_BITS-1:0];
          default: ;
        endcase
      end

      // result transfer frees the output register unless a new result refills it
      if (result.valid && result.ready && (state != ST_DONE)) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            lo_q[0] <= item.lo_x;
            lo_q[1] <= item.lo_y;
            lo_q[2] <= item.lo_z;
            hi_q[0] <= item.hi_x;
            hi_q[1] <= item.hi_y;
            hi_q[2] <= item.hi_z;
            count   <= '0;
            if (item.cmd == CMD_LOAD) begin
              low[0]  <= item.lo_x;
              low[1]  <= item.lo_y;
              low[2]  <= item.lo_z;
              high[0] <= item.hi_x;
              high[1] <= item.hi_y;
              high[2] <= item.hi_z;
              state   <= ST_DONE;
            end else begin
              // periodic mode starts at the (-1,-1,-1) image
              for (int k = 0; k < 3; k++) begin
                off[k] <= periodic_on ? OFF_NEG : OFF_ZERO;
              end
              state <= ST_TEST;
            end
          end
        end

        ST_TEST: begin
          cmin_q <= cmin;
          cmax_q <= cmax;
          if (overlap) begin
            axis  <= AXIS_X;
            side  <= 1'b0;
            state <= ST_PROD;
          end else if (last_image) begin
            state <= ST_DONE;
          end else begin
            off <= off_next;
          end
        end

        ST_PROD: begin
          state <= ST_SPLIT;
        end

        // extent product split into halves for the two partial products
        ST_SPLIT: begin
          p_lo  <= prod[CW-1:0];
          p_hi  <= prod[PW-1:CW];
          state <= ST_MUL_LO;
        end

        ST_MUL_LO: begin
          state <= ST_MUL_HI;
        end

        ST_MUL_HI: begin
          acc   <= {{CW{1'b0}}, prod};
          state <= ST_ACCUM;
        end

        ST_ACCUM: begin
          acc   <= acc + {prod, {CW{1'b0}}};
          state <= ST_CMP;
        end

        ST_CMP: begin
          if (better) begin
            best      <= acc;
            best_axis <= axis;
            best_side <= side;
          end
          if (!side) begin
            side  <= 1'b1;
            state <= ST_MUL_LO;
          end else if (axis == AXIS_Z) begin
            state <= ST_APPLY;
          end else begin
            axis  <= (axis == AXIS_X) ? AXIS_Y : AXIS_Z;
            side  <= 1'b0;
            state <= ST_PROD;
          end
        end

        // trim the chosen side of the chosen axis to the overlap
        ST_APPLY: begin
          for (int k = 0; k < 3; k++) begin
            if (axis_t'(k) == best_axis) begin
              if (best_side) begin
                low[k] <= apply_val;
              end else begin
                high[k] <= apply_val;
              end
            end
          end
          count <= count + 1'b1;
          if (last_image) begin
            state <= ST_DONE;
          end else begin
            off   <= off_next;
            state <= ST_TEST;
          end
        end

        ST_DONE: begin
          if (!result.valid || result.ready) begin
            result.out_lo_x      <= low[0];
            result.out_lo_y      <= low[1];
            result.out_lo_z      <= low[2];
            result.out_hi_x      <= high[0];
            result.out_hi_y      <= high[1];
            result.out_hi_z      <= high[2];
            result.overlap_count <= count;
            result.valid         <= 1'b1;
            state                <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // overlap count never passes the number of images
  a_count_bound: assert property (
    @(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(IMAGE_COUNT)
  ) else $error("overlap count beyond image count");

  // without periodic mode a cut tries a single image
  a_single_image: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_DONE) && !periodic_on |-> count <= COUNT_BITS'(1)
  ) else $error("more than one overlap without periodic mode");

  // a trim always lands inside the current box on its axis
  a_trim_inside: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> (apply_val >= sel_low) && (apply_val <= sel_high)
  ) else $error("trim outside the interior box");

endmodule
